// ===== sv/fup_pkg.sv =====
`timescale 1ns / 1ps
package fup_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_KEY     = 2'd0;
  localparam logic [1:0] KIND_VALUE   = 2'd1;
  localparam logic [1:0] KIND_END_KEY = 2'd2;
  localparam logic [1:0] KIND_END_VAL = 2'd3;

  // Characters with a meaning in the query string syntax.
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // One queue entry: the results caused by one input byte, one or two of them.
  typedef struct packed {
    logic       two;
    logic [1:0] kind0;
    logic [7:0] data0;
    logic [1:0] kind1;
    logic [7:0] data1;
  } fup_entry_t;

endpackage

// ===== sv/fup_if.sv =====
`timescale 1ns / 1ps
interface fup_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

interface fup_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink (input valid, input out_kind, input out_byte, input out_last,
                output ready);
endinterface

// ===== sv/fup_front.sv =====
`timescale 1ns / 1ps
module fup_front (
  input  logic              clk,
  input  logic              rst,
  fup_byte_if.sink          bytes,
  input  logic              full,
  output logic              push,
  output fup_pkg::fup_entry_t entry
);

  localparam logic [2:0] ST_START  = 3'd0;
  localparam logic [2:0] ST_KEY    = 3'd1;
  localparam logic [2:0] ST_VALUE  = 3'd2;
  localparam logic [2:0] ST_KEYESC = 3'd3;
  localparam logic [2:0] ST_VALESC = 3'd4;

  typedef struct packed {
    logic [2:0] state;
    logic       emit;
    logic [1:0] kind;
    logic [7:0] data;
  } fup_plain_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } fup_hex_t;

  function automatic fup_hex_t hex_digit(input logic [7:0] ch);
    fup_hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) h.value = ch[3:0];
    else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46))
      h.value = ch[3:0] + 4'd9;
    else h.valid = 1'b0;
    return h;
  endfunction

  // Handling of a byte outside an escape.
  function automatic fup_plain_t plain_step(input logic [2:0] st, input logic [7:0] ch);
    fup_plain_t p;
    p.state = st;
    p.emit  = 1'b0;
    p.kind  = fup_pkg::KIND_KEY;
    p.data  = 8'd0;
    case (st)
      ST_KEY: begin
        if (ch == fup_pkg::CH_EQUAL) p.state = ST_VALUE;
        else if (ch == fup_pkg::CH_AMP) begin
          p.emit  = 1'b1;
          p.kind  = fup_pkg::KIND_END_KEY;
          p.state = ST_START;
        end else if (ch == fup_pkg::CH_PERCENT) p.state = ST_KEYESC;
        else begin
          p.emit = 1'b1;
          p.data = ch;
        end
      end
      ST_VALUE: begin
        if (ch == fup_pkg::CH_PERCENT) p.state = ST_VALESC;
        else if (ch == fup_pkg::CH_AMP) begin
          p.emit  = 1'b1;
          p.kind  = fup_pkg::KIND_END_VAL;
          p.state = ST_START;
        end else begin
          p.emit = 1'b1;
          p.kind = fup_pkg::KIND_VALUE;
          p.data = (ch == fup_pkg::CH_PLUS) ? fup_pkg::CH_SPACE : ch;
        end
      end
      default: begin
        if (ch == fup_pkg::CH_EQUAL) p.state = ST_VALUE;
        else if (ch == fup_pkg::CH_AMP) p.state = ST_START;
        else if (ch == fup_pkg::CH_PERCENT) p.state = ST_KEYESC;
        else begin
          p.emit  = 1'b1;
          p.data  = ch;
          p.state = ST_KEY;
        end
      end
    endcase
    return p;
  endfunction

  logic [2:0] state, state_next;
  logic       hex_seen, hex_seen_next;
  logic [3:0] hex_accum, hex_accum_next;
  logic       accept, in_esc, found;
  logic [2:0] back_state;
  logic [1:0] esc_kind;
  fup_hex_t   hex;
  fup_plain_t pl;

  assign bytes.ready = !full;
  assign accept      = bytes.valid && !full;
  assign push        = accept && found;

  always_comb begin
    in_esc     = (state == ST_KEYESC) || (state == ST_VALESC);
    back_state = (state == ST_KEYESC) ? ST_KEY : ST_VALUE;
    esc_kind   = (state == ST_KEYESC) ? fup_pkg::KIND_KEY : fup_pkg::KIND_VALUE;
    hex        = hex_digit(bytes.in_char);
    pl         = plain_step(in_esc ? back_state : state, bytes.in_char);

    state_next     = state;
    hex_seen_next  = hex_seen;
    hex_accum_next = hex_accum;
    found          = 1'b0;
    entry          = '0;

    if (in_esc) begin
      entry.kind0 = esc_kind;
      if (hex.valid) begin
        if (hex_seen) begin
          found          = 1'b1;
          entry.data0    = {hex_accum, hex.value};
          state_next     = back_state;
          hex_seen_next  = 1'b0;
          hex_accum_next = 4'd0;
        end else begin
          hex_seen_next  = 1'b1;
          hex_accum_next = hex.value;
        end
      end else begin
        // A cut-short escape gives its pending byte, then the byte is parsed.
        found          = 1'b1;
        entry.data0    = hex_seen ? {4'd0, hex_accum} : fup_pkg::CH_PERCENT;
        entry.two      = pl.emit;
        entry.kind1    = pl.kind;
        entry.data1    = pl.data;
        state_next     = pl.state;
        hex_seen_next  = 1'b0;
        hex_accum_next = 4'd0;
      end
    end else begin
      found       = pl.emit;
      entry.kind0 = pl.kind;
      entry.data0 = pl.data;
      state_next  = pl.state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_START;
      hex_seen  <= 1'b0;
      hex_accum <= 4'd0;
    end else if (accept) begin
      state     <= state_next;
      hex_seen  <= hex_seen_next;
      hex_accum <= hex_accum_next;
    end
  end

endmodule

// ===== sv/fup_queue.sv =====
`timescale 1ns / 1ps
module fup_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fup_pkg::fup_entry_t push_entry,
  input  logic                pop,
  output fup_pkg::fup_entry_t head,
  output logic                empty,
  output logic                full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  fup_pkg::fup_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== sv/fup_back.sv =====
`timescale 1ns / 1ps
module fup_back (
  input  logic                clk,
  input  logic                rst,
  input  fup_pkg::fup_entry_t head,
  input  logic                empty,
  output logic                pop,
  fup_result_if.source        results
);

  // Set while the second result of a two-result entry is on offer.
  logic phase;
  logic beat;

  assign results.valid    = !empty;
  assign results.out_kind = phase ? head.kind1 : head.kind0;
  assign results.out_byte = phase ? head.data1 : head.data0;
  assign results.out_last = phase || !head.two;

  assign beat = results.valid && results.ready;
  assign pop  = beat && results.out_last;

  always_ff @(posedge clk) begin
    if (rst) phase <= 1'b0;
    else if (beat) phase <= !results.out_last;
  end

endmodule

// ===== sv/form_urlencoded_parser_unit.sv =====
`timescale 1ns / 1ps
// A result is registered in the result queue before it is offered on the result port.
// Throughput: one input byte per cycle while the output is ready and each byte gives at most
// one result; the output gives one result beat per cycle while ready and the queue is not
// empty, so a byte with two results takes one beat per result and can hold up the input.
// Reset (synchronous, active high) returns the parser to the start state before
// any key, clears the escape digit and empties the result queue.
module form_urlencoded_parser_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  fup_byte_if.sink     bytes,
  fup_result_if.source results
);

  // The front runs the parse state machine. Every byte that causes any result
  // turns into one queue entry holding one or two results; bytes that only move
  // the state (such as '=' after a key or the first hex digit of an escape) push
  // nothing. The front takes a byte in every cycle in which the queue has room.
  //
  // The back walks the head entry one result per beat and marks the last result
  // of each byte with out_last. The queue between them lets the output stall
  // without stopping the input until the queue fills.

  fup_pkg::fup_entry_t push_entry, head;
  logic                push, pop, empty, full;

  fup_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .full  (full),
    .push  (push),
    .entry (push_entry)
  );

  fup_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  fup_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .results (results)
  );

  // The front never pushes into a full queue, since it only takes bytes when there is room.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into a full result queue");

  // A beat that is not the last of its byte is followed by the rest of that byte.
  a_rest_follows: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && !results.out_last |=> results.valid)
    else $error("second result of a byte went missing");

  // Pair-end markers carry a zero byte.
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.out_kind[1] |-> results.out_byte == 8'd0)
    else $error("pair-end marker with a nonzero byte");

  // The first of two results of one byte is always the pending escape byte,
  // so it is a key or value byte and never a pair end.
  a_first_is_data: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.out_last |-> !results.out_kind[1])
    else $error("pair end offered before another result of the same byte");

endmodule
